### sv/whp_pkg.sv
// Shared types and constants for the WAV header parser.
`timescale 1ns / 1ps

package whp_pkg;

  // Parser phases
  localparam logic [3:0] PH_RIFF      = 4'd0;
  localparam logic [3:0] PH_FMT_ID    = 4'd1;
  localparam logic [3:0] PH_FMT_SKSZ  = 4'd2;
  localparam logic [3:0] PH_FMT_SKIP  = 4'd3;
  localparam logic [3:0] PH_FMT_SIZE  = 4'd4;
  localparam logic [3:0] PH_FMT_BODY  = 4'd5;
  localparam logic [3:0] PH_FMT_EXTRA = 4'd6;
  localparam logic [3:0] PH_DAT_ID    = 4'd7;
  localparam logic [3:0] PH_DAT_SKSZ  = 4'd8;
  localparam logic [3:0] PH_DAT_SKIP  = 4'd9;
  localparam logic [3:0] PH_DAT_SIZE  = 4'd10;
  localparam logic [3:0] PH_DONE      = 4'd11;

  // Result status codes
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_BAD_FMT   = 3'd2;
  localparam logic [2:0] ST_BAD_CHAN  = 3'd3;
  localparam logic [2:0] ST_BAD_RATE  = 3'd4;
  localparam logic [2:0] ST_BAD_BITS  = 3'd5;
  localparam logic [2:0] ST_TRUNC     = 3'd6;
  localparam logic [2:0] ST_IGNORED   = 3'd7;

  // Configuration register indexes
  localparam logic [7:0] REG_FORMAT   = 8'd0;
  localparam logic [7:0] REG_CHANNELS = 8'd1;
  localparam logic [7:0] REG_RATE     = 8'd2;
  localparam logic [7:0] REG_BITS     = 8'd3;

  // Chunk ids as they appear in the little-endian shift register
  localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA  = 32'h6174_6164;
  localparam logic [31:0] FMT_CORE = 32'd16;
  localparam logic [31:0] FIELD4   = 32'd4;
  localparam logic [31:0] RIFF_LEN = 32'd12;

  // Capture register reset values
  localparam logic [15:0] RST_FORMAT   = 16'd1;
  localparam logic [15:0] RST_CHANNELS = 16'd1;
  localparam logic [31:0] RST_RATE     = 32'd44100;
  localparam logic [31:0] RST_BYTERATE = 32'd88200;
  localparam logic [15:0] RST_ALIGN    = 16'd2;
  localparam logic [15:0] RST_BITS     = 16'd16;

  typedef struct packed {
    logic [15:0] exp_format;
    logic [15:0] exp_channels;
    logic [31:0] exp_rate;
    logic [15:0] exp_bits;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
    logic [31:0] riff_size;
  } result_t;

endpackage

### sv/wav_header_parser_core.sv
// Top level of the WAV header parser: config registers, parser and output skid buffer.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_stall     data_byte, restart, end_of_stream
//   out_     output     out_valid / out_stall   status and eight captured fields
//   cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; with the output free, a byte's result is valid
// in the cycle after its transfer. The phase machine updates in the cycle a byte is taken;
// the result lands in an output register, with a second skid entry so a byte
// can be taken while a result waits. in_stall rises only when both entries are full.
// Reset (synchronous, rst_n low) returns the parser and the expected values to
// their defaults and empties both entries.
`timescale 1ns / 1ps

module wav_header_parser_core import whp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_audio_format,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_byte_rate,
  output logic [15:0] out_block_align,
  output logic [15:0] out_bits_per_sample,
  output logic [31:0] out_data_size,
  output logic [31:0] out_riff_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg_r;
  result_t res;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  logic    in_xfer, out_xfer, out_free;

  // Expected-value registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exp_format   <= 16'd1;
      cfg_r.exp_channels <= 16'd1;
      cfg_r.exp_rate     <= 32'd44100;
      cfg_r.exp_bits     <= 16'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORMAT:   cfg_r.exp_format   <= cfg_data[15:0];
        REG_CHANNELS: cfg_r.exp_channels <= cfg_data[15:0];
        REG_RATE:     cfg_r.exp_rate     <= cfg_data;
        REG_BITS:     cfg_r.exp_bits     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || out_xfer;

  whp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_xfer),
    .data_byte     (in_data_byte),
    .restart       (in_restart),
    .end_of_stream (in_end_of_stream),
    .cfg           (cfg_r),
    .res           (res)
  );

  // Output register plus skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_free) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_audio_format    = out_r.audio_format;
  assign out_channel_count   = out_r.channel_count;
  assign out_sample_rate     = out_r.sample_rate;
  assign out_byte_rate       = out_r.byte_rate;
  assign out_block_align     = out_r.block_align;
  assign out_bits_per_sample = out_r.bits_per_sample;
  assign out_data_size       = out_r.data_size;
  assign out_riff_size       = out_r.riff_size;

  // The skid entry is only used behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  // After every accepted byte the output register holds a result in the next cycle
  a_xfer_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted byte produced no result");

  // A byte taken behind a stalled result goes to the skid entry
  a_xfer_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("result lost behind stalled output");

endmodule

### sv/whp_parse.sv
// Byte-wise RIFF/WAVE header phase machine with capture registers.
`timescale 1ns / 1ps

module whp_parse import whp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  input  logic        end_of_stream,
  input  cfg_t        cfg,
  output result_t     res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] bc_r, bc_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] sz_r, sz_nxt;
  logic [31:0] fmtlen_r, fmtlen_nxt;
  logic [15:0] format_r, format_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic [31:0] rsize_r, rsize_nxt;

  // Current view: a restart byte sees the cleared state
  logic [3:0]  c_phase;
  logic [31:0] c_bc, c_id, c_sz, c_fmtlen, c_rate, c_brate, c_dsize, c_rsize;
  logic [15:0] c_format, c_chan, c_align, c_bits;
  logic [31:0] bc_inc, bc_dec, id_sh, sz_sh;
  logic [2:0]  st, chk;

  always_comb begin
    c_phase  = restart ? PH_RIFF      : phase_r;
    c_bc     = restart ? 32'd0        : bc_r;
    c_id     = restart ? 32'd0        : id_r;
    c_sz     = restart ? 32'd0        : sz_r;
    c_fmtlen = restart ? 32'd0        : fmtlen_r;
    c_format = restart ? RST_FORMAT   : format_r;
    c_chan   = restart ? RST_CHANNELS : chan_r;
    c_rate   = restart ? RST_RATE     : rate_r;
    c_brate  = restart ? RST_BYTERATE : brate_r;
    c_align  = restart ? RST_ALIGN    : align_r;
    c_bits   = restart ? RST_BITS     : bits_r;
    c_dsize  = restart ? 32'd0        : dsize_r;
    c_rsize  = restart ? 32'd0        : rsize_r;
  end

  assign bc_inc = c_bc + 32'd1;
  assign bc_dec = c_bc - 32'd1;
  assign id_sh  = {data_byte, c_id[31:8]};
  assign sz_sh  = {data_byte, c_sz[31:8]};

  // Validation in priority order: format, channels, rate, bits
  always_comb begin
    if (c_format != cfg.exp_format) begin
      chk = ST_BAD_FMT;
    end else if (c_chan != cfg.exp_channels) begin
      chk = ST_BAD_CHAN;
    end else if (c_rate != cfg.exp_rate) begin
      chk = ST_BAD_RATE;
    end else if (c_bits != cfg.exp_bits) begin
      chk = ST_BAD_BITS;
    end else begin
      chk = ST_OK;
    end
  end

  // Advance the phase machine by one byte
  always_comb begin
    phase_nxt  = c_phase;
    bc_nxt     = c_bc;
    id_nxt     = c_id;
    sz_nxt     = c_sz;
    fmtlen_nxt = c_fmtlen;
    format_nxt = c_format;
    chan_nxt   = c_chan;
    rate_nxt   = c_rate;
    brate_nxt  = c_brate;
    align_nxt  = c_align;
    bits_nxt   = c_bits;
    dsize_nxt  = c_dsize;
    rsize_nxt  = c_rsize;
    st         = ST_BUSY;
    case (c_phase)
      PH_RIFF: begin
        if (c_bc >= 32'd4 && c_bc < 32'd8) rsize_nxt = {data_byte, c_rsize[31:8]};
        bc_nxt = bc_inc;
        if (bc_inc == RIFF_LEN) begin
          phase_nxt = PH_FMT_ID;
          bc_nxt    = 32'd0;
        end
      end
      PH_FMT_ID, PH_DAT_ID: begin
        id_nxt = id_sh;
        bc_nxt = bc_inc;
        if (bc_inc == FIELD4) begin
          bc_nxt = 32'd0;
          if (c_phase == PH_FMT_ID) phase_nxt = (id_sh == ID_FMT) ? PH_FMT_SIZE : PH_FMT_SKSZ;
          else phase_nxt = (id_sh == ID_DATA) ? PH_DAT_SIZE : PH_DAT_SKSZ;
        end
      end
      PH_FMT_SKSZ, PH_DAT_SKSZ: begin
        sz_nxt = sz_sh;
        bc_nxt = bc_inc;
        if (bc_inc == FIELD4) begin
          bc_nxt = sz_sh;
          if (sz_sh == 32'd0) phase_nxt = (c_phase == PH_FMT_SKSZ) ? PH_FMT_ID : PH_DAT_ID;
          else phase_nxt = (c_phase == PH_FMT_SKSZ) ? PH_FMT_SKIP : PH_DAT_SKIP;
        end
      end
      PH_FMT_SKIP, PH_DAT_SKIP, PH_FMT_EXTRA: begin
        bc_nxt = bc_dec;
        if (bc_dec == 32'd0) phase_nxt = (c_phase == PH_FMT_SKIP) ? PH_FMT_ID : PH_DAT_ID;
      end
      PH_FMT_SIZE: begin
        sz_nxt = sz_sh;
        bc_nxt = bc_inc;
        if (bc_inc == FIELD4) begin
          fmtlen_nxt = sz_sh;
          bc_nxt     = 32'd0;
          phase_nxt  = PH_FMT_BODY;
        end
      end
      PH_FMT_BODY: begin
        if (c_bc < 32'd2) format_nxt = {data_byte, c_format[15:8]};
        else if (c_bc < 32'd4) chan_nxt = {data_byte, c_chan[15:8]};
        else if (c_bc < 32'd8) rate_nxt = {data_byte, c_rate[31:8]};
        else if (c_bc < 32'd12) brate_nxt = {data_byte, c_brate[31:8]};
        else if (c_bc < 32'd14) align_nxt = {data_byte, c_align[15:8]};
        else bits_nxt = {data_byte, c_bits[15:8]};
        bc_nxt = bc_inc;
        if (bc_inc == FMT_CORE) begin
          if (c_fmtlen > FMT_CORE) begin
            bc_nxt    = c_fmtlen - FMT_CORE;
            phase_nxt = PH_FMT_EXTRA;
          end else begin
            bc_nxt    = 32'd0;
            phase_nxt = PH_DAT_ID;
          end
        end
      end
      PH_DAT_SIZE: begin
        dsize_nxt = {data_byte, c_dsize[31:8]};
        bc_nxt    = bc_inc;
        if (bc_inc == FIELD4) begin
          bc_nxt    = 32'd0;
          phase_nxt = PH_DONE;
          st        = chk;
        end
      end
      default: begin
        st = ST_IGNORED;
      end
    endcase
    // Drop to done on an early end of stream
    if (st == ST_BUSY && end_of_stream) begin
      st        = ST_TRUNC;
      phase_nxt = PH_DONE;
      bc_nxt    = 32'd0;
    end
  end

  // Hold state between transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RIFF;
      bc_r     <= 32'd0;
      id_r     <= 32'd0;
      sz_r     <= 32'd0;
      fmtlen_r <= 32'd0;
      format_r <= RST_FORMAT;
      chan_r   <= RST_CHANNELS;
      rate_r   <= RST_RATE;
      brate_r  <= RST_BYTERATE;
      align_r  <= RST_ALIGN;
      bits_r   <= RST_BITS;
      dsize_r  <= 32'd0;
      rsize_r  <= 32'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      bc_r     <= bc_nxt;
      id_r     <= id_nxt;
      sz_r     <= sz_nxt;
      fmtlen_r <= fmtlen_nxt;
      format_r <= format_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      brate_r  <= brate_nxt;
      align_r  <= align_nxt;
      bits_r   <= bits_nxt;
      dsize_r  <= dsize_nxt;
      rsize_r  <= rsize_nxt;
    end
  end

  assign res.status          = st;
  assign res.audio_format    = format_nxt;
  assign res.channel_count   = chan_nxt;
  assign res.sample_rate     = rate_nxt;
  assign res.byte_rate       = brate_nxt;
  assign res.block_align     = align_nxt;
  assign res.bits_per_sample = bits_nxt;
  assign res.data_size       = dsize_nxt;
  assign res.riff_size       = rsize_nxt;

endmodule

### verif/wav_header_checker.sv
// Checker for the WAV header parser: predicts every result and compares it on transfer.
`timescale 1ns / 1ps

module wav_header_checker import whp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  input  logic        in_end_of_stream,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_audio_format,
  input  logic [15:0] out_channel_count,
  input  logic [31:0] out_sample_rate,
  input  logic [31:0] out_byte_rate,
  input  logic [15:0] out_block_align,
  input  logic [15:0] out_bits_per_sample,
  input  logic [31:0] out_data_size,
  input  logic [31:0] out_riff_size,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int unsigned outstanding,
  output int unsigned fail_count
);

  // Values the header is validated against
  cfg_t        accept;
  // Capture registers of the parser; status is filled per byte
  result_t     capture;
  logic [3:0]  ph;
  logic [31:0] cnt;
  logic [31:0] id_sr;
  logic [31:0] size_sr;
  logic [31:0] fmt_len;
  result_t     due_reports[$];
  result_t     head;
  int unsigned errs = 0;

  assign fail_count = errs;

  function automatic logic [15:0] shift16(input logic [15:0] r, input logic [7:0] b);
    return {b, r[15:8]};
  endfunction

  // Return the parse state and captured fields to their power-up values
  task automatic clear_capture();
    ph      = PH_RIFF;
    cnt     = '0;
    id_sr   = '0;
    size_sr = '0;
    fmt_len = '0;
    capture = '0;
    capture.audio_format    = RST_FORMAT;
    capture.channel_count   = RST_CHANNELS;
    capture.sample_rate     = RST_RATE;
    capture.byte_rate       = RST_BYTERATE;
    capture.block_align     = RST_ALIGN;
    capture.bits_per_sample = RST_BITS;
  endtask

  // Advance the phase machine by one byte and queue the result it gives
  task automatic predict_report(input logic [7:0] b, input logic rs, input logic eos);
    logic [2:0] st;
    st = ST_BUSY;
    if (rs) clear_capture();
    case (ph)
      PH_RIFF: begin
        if (cnt >= 4 && cnt < 8) capture.riff_size = {b, capture.riff_size[31:8]};
        cnt = cnt + 1;
        if (cnt == RIFF_LEN) begin
          ph  = PH_FMT_ID;
          cnt = '0;
        end
      end
      PH_FMT_ID, PH_DAT_ID: begin
        id_sr = {b, id_sr[31:8]};
        cnt   = cnt + 1;
        if (cnt == FIELD4) begin
          cnt = '0;
          if (ph == PH_FMT_ID) ph = (id_sr == ID_FMT) ? PH_FMT_SIZE : PH_FMT_SKSZ;
          else ph = (id_sr == ID_DATA) ? PH_DAT_SIZE : PH_DAT_SKSZ;
        end
      end
      PH_FMT_SKSZ, PH_DAT_SKSZ: begin
        size_sr = {b, size_sr[31:8]};
        cnt     = cnt + 1;
        if (cnt == FIELD4) begin
          cnt = size_sr;
          // a zero-sized chunk goes straight back to the id search
          if (size_sr == 0) ph = (ph == PH_FMT_SKSZ) ? PH_FMT_ID : PH_DAT_ID;
          else ph = (ph == PH_FMT_SKSZ) ? PH_FMT_SKIP : PH_DAT_SKIP;
        end
      end
      PH_FMT_SKIP, PH_DAT_SKIP, PH_FMT_EXTRA: begin
        cnt = cnt - 1;
        if (cnt == 0) ph = (ph == PH_FMT_SKIP) ? PH_FMT_ID : PH_DAT_ID;
      end
      PH_FMT_SIZE: begin
        size_sr = {b, size_sr[31:8]};
        cnt     = cnt + 1;
        if (cnt == FIELD4) begin
          fmt_len = size_sr;
          cnt     = '0;
          ph      = PH_FMT_BODY;
        end
      end
      PH_FMT_BODY: begin
        if (cnt < 2) capture.audio_format = shift16(capture.audio_format, b);
        else if (cnt < 4) capture.channel_count = shift16(capture.channel_count, b);
        else if (cnt < 8) capture.sample_rate = {b, capture.sample_rate[31:8]};
        else if (cnt < 12) capture.byte_rate = {b, capture.byte_rate[31:8]};
        else if (cnt < 14) capture.block_align = shift16(capture.block_align, b);
        else capture.bits_per_sample = shift16(capture.bits_per_sample, b);
        cnt = cnt + 1;
        // a short fmt size still reads the full core and skips nothing
        if (cnt == FMT_CORE) begin
          if (fmt_len > FMT_CORE) begin
            cnt = fmt_len - FMT_CORE;
            ph  = PH_FMT_EXTRA;
          end else begin
            cnt = '0;
            ph  = PH_DAT_ID;
          end
        end
      end
      PH_DAT_SIZE: begin
        capture.data_size = {b, capture.data_size[31:8]};
        cnt = cnt + 1;
        if (cnt == FIELD4) begin
          cnt = '0;
          ph  = PH_DONE;
          if (capture.audio_format != accept.exp_format) st = ST_BAD_FMT;
          else if (capture.channel_count != accept.exp_channels) st = ST_BAD_CHAN;
          else if (capture.sample_rate != accept.exp_rate) st = ST_BAD_RATE;
          else if (capture.bits_per_sample != accept.exp_bits) st = ST_BAD_BITS;
          else st = ST_OK;
        end
      end
      default: st = ST_IGNORED;
    endcase
    // end of stream before the header completes
    if (st == ST_BUSY && eos) begin
      st  = ST_TRUNC;
      ph  = PH_DONE;
      cnt = '0;
    end
    capture.status = st;
    due_reports.push_back(capture);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errs = errs + 1;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      accept.exp_format   = 16'd1;
      accept.exp_channels = 16'd1;
      accept.exp_rate     = 32'd44100;
      accept.exp_bits     = 16'd16;
      clear_capture();
      due_reports.delete();
      outstanding <= 0;
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORMAT:   accept.exp_format   = cfg_data[15:0];
          REG_CHANNELS: accept.exp_channels = cfg_data[15:0];
          REG_RATE:     accept.exp_rate     = cfg_data;
          REG_BITS:     accept.exp_bits     = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_report(in_data_byte, in_restart, in_end_of_stream);
      // compare each result transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          errs = errs + 1;
          $display("%0t: result mismatch, expected none, got status %0d", $time, out_status);
        end else begin
          head = due_reports.pop_front();
          check_field("status", 32'(head.status), 32'(out_status));
          check_field("audio_format", 32'(head.audio_format), 32'(out_audio_format));
          check_field("channel_count", 32'(head.channel_count), 32'(out_channel_count));
          check_field("sample_rate", head.sample_rate, out_sample_rate);
          check_field("byte_rate", head.byte_rate, out_byte_rate);
          check_field("block_align", 32'(head.block_align), 32'(out_block_align));
          check_field("bits_per_sample", 32'(head.bits_per_sample),
                      32'(out_bits_per_sample));
          check_field("data_size", head.data_size, out_data_size);
          check_field("riff_size", head.riff_size, out_riff_size);
        end
      end
      outstanding <= due_reports.size();
    end
  end

endmodule

### verif/testbench.sv
// Top of the WAV header parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import whp_pkg::*;

  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_restart = 1'b0;
  logic        in_end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_audio_format;
  logic [15:0] out_channel_count;
  logic [31:0] out_sample_rate;
  logic [31:0] out_byte_rate;
  logic [15:0] out_block_align;
  logic [15:0] out_bits_per_sample;
  logic [31:0] out_data_size;
  logic [31:0] out_riff_size;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'h00;
  logic [31:0] cfg_data = 32'h0;
  int unsigned outstanding;
  int unsigned fail_count;

  // Stimulus state
  cfg_t        rules;
  logic [7:0]  wave_bytes[$];
  int unsigned fed_bytes = 0;
  bit          send_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  int unsigned stall_hold = 0;
  int unsigned stall_pick;

  wav_header_parser_core u_dut (.*);
  wav_header_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Result-side backpressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_quiet) begin
      out_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 3);
      end else if (stall_pick < 93) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(8, 30);
      end
    end
  end

  // Present one byte after a random gap and hold it until its transfer
  task automatic send_byte(input logic [7:0] b, input logic rs, input logic eos);
    int unsigned r;
    int unsigned gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!send_quiet && r >= 55) gap = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_restart       <= rs;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off the sender until every predicted result has been taken
  task automatic wait_reports_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write the four expected values, optionally plus an unused index
  task automatic write_rules(input logic [15:0] fmt, input logic [15:0] chans,
                             input logic [31:0] rate, input logic [15:0] bits,
                             input bit poke_spare);
    logic [7:0]  idx;
    logic [31:0] val;
    logic [15:0] junk;
    rules.exp_format   = fmt;
    rules.exp_channels = chans;
    rules.exp_rate     = rate;
    rules.exp_bits     = bits;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4 + poke_spare; i++) begin
      junk = 16'($urandom);
      case (i)
        0: begin idx = REG_FORMAT;   val = {junk, fmt};   end
        1: begin idx = REG_CHANNELS; val = {junk, chans}; end
        2: begin idx = REG_RATE;     val = rate;          end
        3: begin idx = REG_BITS;     val = {junk, bits};  end
        default: begin
          idx = 8'($urandom_range(REG_BITS + 1, 255));
          val = $urandom;
        end
      endcase
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic put_le(input logic [31:0] v, input int unsigned n);
    for (int k = 0; k < n; k++) wave_bytes.push_back(v[8*k +: 8]);
  endtask

  task automatic put_tag(input logic [31:0] t);
    for (int k = 3; k >= 0; k--) wave_bytes.push_back(t[8*k +: 8]);
  endtask

  task automatic put_random(input int unsigned n);
    repeat (n) wave_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Unknown chunk: random id, small size (often zero), random body
  task automatic put_skip_chunk();
    int unsigned len;
    len = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 9);
    put_tag($urandom);
    put_le(len, 4);
    put_random(len);
  endtask

  // Build one file with random content, mostly well-formed, then feed it,
  // sometimes cut short or restarted partway
  task automatic send_wave_file();
    int unsigned r;
    int unsigned fmt_size;
    int unsigned hdr_len;
    int unsigned cut;
    int unsigned jolt;
    logic [15:0] fmt;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    bit          first_rs;
    wave_bytes.delete();
    put_tag(($urandom_range(0, 7) == 0) ? $urandom : TAG_RIFF);
    put_le($urandom, 4);
    put_tag(($urandom_range(0, 7) == 0) ? $urandom : TAG_WAVE);
    r = $urandom_range(0, 99);
    repeat ((r < 50) ? 0 : (r < 80) ? 1 : 2) put_skip_chunk();
    // fmt chunk: mostly the plain size, some with extra bytes, some too short
    put_tag(TAG_FMT);
    r = $urandom_range(0, 99);
    fmt_size = (r < 70) ? 16 : (r < 85) ? $urandom_range(17, 22) : $urandom_range(0, 15);
    put_le(fmt_size, 4);
    fmt   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : rules.exp_format;
    chans = ($urandom_range(0, 9) == 0) ? 16'($urandom) : rules.exp_channels;
    rate  = ($urandom_range(0, 9) == 0) ? $urandom : rules.exp_rate;
    bits  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : rules.exp_bits;
    put_le({16'h0, fmt}, 2);
    put_le({16'h0, chans}, 2);
    put_le(rate, 4);
    put_le(($urandom_range(0, 3) == 0) ? $urandom : rate * chans * bits / 8, 4);
    put_le($urandom, 2);
    put_le({16'h0, bits}, 2);
    if (fmt_size > 16) put_random(fmt_size - 16);
    r = $urandom_range(0, 99);
    repeat ((r < 50) ? 0 : (r < 80) ? 1 : 2) put_skip_chunk();
    put_tag(TAG_DATA);
    r = $urandom_range(0, 99);
    put_le((r < 10) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF : $urandom, 4);
    hdr_len = wave_bytes.size();
    // trailing bytes land after the parser has stopped
    put_random($urandom_range(0, 3));

    r        = $urandom_range(0, 99);
    cut      = (r < 12) ? $urandom_range(0, hdr_len - 2) :
               (r < 17) ? hdr_len - 1 : wave_bytes.size();
    jolt     = (r >= 17 && r < 23) ? $urandom_range(1, hdr_len - 1) : wave_bytes.size();
    first_rs = ($urandom_range(0, 9) != 0);
    for (int i = 0; i < wave_bytes.size(); i++)
      send_byte(wave_bytes[i], (i == 0) ? first_rs : (i == jolt),
                (i == cut) || (i >= hdr_len && $urandom_range(0, 3) == 0));
    fed_bytes = fed_bytes + wave_bytes.size();
  endtask

  // Random bytes with random restart and end flags
  task automatic send_noise();
    int unsigned len;
    len = $urandom_range(3, 20);
    repeat (len)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                $urandom_range(0, 7) == 0);
    fed_bytes = fed_bytes + len;
  endtask

  initial begin
    int unsigned step;
    int unsigned r;
    rules.exp_format   = 16'd1;
    rules.exp_channels = 16'd1;
    rules.exp_rate     = 32'd44100;
    rules.exp_bits     = 16'd16;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Short streams: early end, bytes after stop, restart with end on one byte
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b1);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0);

    // Random files under a series of expected-value settings
    for (step = 0; step < 6; step++) begin
      if (step != 0) begin
        wait_reports_drained();
        case (step)
          1: write_rules(16'd1, 16'd2, 32'd48000, 16'd24, 1'b0);
          2: write_rules(16'h0, 16'h0, 32'h0, 16'h0, 1'b0);
          3: write_rules(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
          4: write_rules(16'($urandom), 16'($urandom), $urandom, 16'($urandom), 1'b0);
          default: write_rules(16'd1, 16'd1, 32'd44100, 16'd16, 1'b0);
        endcase
      end
      while (fed_bytes < (step + 1) * 325) begin
        send_quiet = ($urandom_range(0, 4) == 0);
        out_quiet  = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 85) send_wave_file();
        else if (r < 95) send_noise();
        else wait_reports_drained();
      end
    end

    wait_reports_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### files.f
sv/whp_pkg.sv
sv/whp_parse.sv
sv/wav_header_parser_core.sv
verif/wav_header_checker.sv
verif/testbench.sv
